>>> src/tcw_pkg.sv
// Shared types and constants for the text console character writer.
`default_nettype none

package tcw_pkg;

    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CURSOR_W    = 11;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_WIPE,
        S_BLANK
    } tcw_state_t;

endpackage

`default_nettype wire

>>> src/tcw_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/text_console_char_writer_top.sv
// Text console engine: screen store, cursor, put/read handling and scroll-up.
// Flow: one item is worked on at a time. A read passes S_IDLE, which issues the RAM read,
//   then S_READ, which registers the result. A put writes its character in S_IDLE (a newline
//   writes none), then S_BLANK writes the blank at the new cursor and registers the result;
//   a put that scrolls passes S_COPY (one cell per cycle, single RAM write port) and S_WIPE first.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
//   ROWS*COLUMNS cells with s_tready low; config writes are taken throughout.
`default_nettype none

module text_console_char_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  wire         aclk,
    input  wire         aresetn,
    // config
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,      // text_attribute
    // input beats
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,        // [7:0] char_code, [18:8] read_index, rest zero
    input  wire  [0:0]  s_tuser,        // [0] op
    // result beats
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata         // [10:0] cursor_pos, [26:11] cell_data, [27] scrolled
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);      // cell address
    localparam int CW     = $clog2(CELLS + 1);  // counters that may hold CELLS
    localparam int COLW   = $clog2(COLUMNS);
    localparam int COPY_N = (ROWS - 1) * COLUMNS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tcw_state_t          state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;        // sweep / copy counter
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [COLW-1:0]     col_reg, col_next;        // column of cursor
    logic [AW-1:0]       pos_reg, pos_next;        // cursor after the put in flight
    logic [AW-1:0]       cp_dst_reg, cp_dst_next;  // copy destination of read in flight
    logic                cp_pend_reg, cp_pend_next;
    logic                scrl_reg, scrl_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [ATTR_W-1:0]   attr_reg;

    logic                m_valid_reg, m_valid_next;
    logic [CURSOR_W-1:0] out_cur_reg;
    logic [CELL_W-1:0]   out_data_reg;
    logic                out_scrl_reg;

    // ------------------------------------------------------------------
    // Screen RAM
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Input fields and derived values
    // ------------------------------------------------------------------
    logic                in_op;
    logic [CHAR_W-1:0]   in_char;
    logic [INDEX_W-1:0]  in_index;
    logic [AW+INDEX_W-1:0]    index_ext;
    logic                     index_ok;
    logic [AW+CURSOR_W-1:0]   cur_ext;
    logic [AW+CURSOR_W-1:0]   pos_ext;
    logic [CW-1:0]            put_pos;     // cursor after the character, may reach CELLS
    logic                     out_free;
    logic [CELL_W-1:0]        blank_cell;

    assign in_op      = s_tuser[0];
    assign in_char    = s_tdata[7:0];
    assign in_index   = s_tdata[18:8];
    assign index_ext  = {{AW{1'b0}}, in_index};
    assign index_ok   = 32'(in_index) < 32'(CELLS);
    assign cur_ext    = {{CURSOR_W{1'b0}}, cursor_reg};
    assign pos_ext    = {{CURSOR_W{1'b0}}, pos_reg};
    assign out_free   = !m_valid_reg || m_tready;
    assign blank_cell = {attr_reg, BLANK_CODE};

    // Newline: start of next row. Otherwise step by one cell.
    always_comb begin
        if (in_char == NEWLINE_CODE) begin
            put_pos = CW'(cursor_reg) - CW'(col_reg) + CW'(COLUMNS);
        end else begin
            put_pos = CW'(cursor_reg) + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            idx_reg     <= '0;
            cursor_reg  <= '0;
            col_reg     <= '0;
            cp_pend_reg <= 1'b0;
            scrl_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            attr_reg    <= ATTR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cursor_reg  <= cursor_next;
            col_reg     <= col_next;
            cp_pend_reg <= cp_pend_next;
            scrl_reg    <= scrl_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    logic                out_load;
    logic [AW-1:0]       out_cur_sel;
    logic [CELL_W-1:0]   out_data_sel;
    logic                out_scrl_sel;
    logic [AW+CURSOR_W-1:0] out_cur_ext;

    assign out_cur_ext = {{CURSOR_W{1'b0}}, out_cur_sel};

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        cp_dst_reg <= cp_dst_next;
        if (out_load) begin
            out_cur_reg  <= out_cur_ext[CURSOR_W-1:0];
            out_data_reg <= out_data_sel;
            out_scrl_reg <= out_scrl_sel;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        pos_next     = pos_reg;
        cp_dst_next  = cp_dst_reg;
        cp_pend_next = cp_pend_reg;
        scrl_next    = scrl_reg;
        rd_ok_next   = rd_ok_reg;
        m_valid_next = m_valid_reg && !m_tready;

        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = index_ext[AW-1:0];

        s_tready     = 1'b0;
        out_load     = 1'b0;
        out_cur_sel  = cursor_reg;
        out_data_sel = '0;
        out_scrl_sel = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                // post-reset clearing pass
                ram_we = 1'b1;
                if (idx_reg == CW'(CELLS - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_op == OP_READ) begin
                        ram_re     = index_ok;
                        rd_ok_next = index_ok;
                        state_next = S_READ;
                    end else begin
                        if (in_char == NEWLINE_CODE) begin
                            col_next = '0;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = cursor_reg;
                            ram_wdata = {attr_reg, in_char};
                            col_next  = (col_reg == COLW'(COLUMNS - 1)) ?
                                        '0 : col_reg + COLW'(1);
                        end
                        if (put_pos >= CW'(CELLS)) begin
                            // off the bottom: scroll up one row
                            scrl_next    = 1'b1;
                            pos_next     = AW'(CELLS - COLUMNS);
                            col_next     = '0;
                            idx_next     = '0;
                            cp_pend_next = 1'b0;
                            state_next   = S_COPY;
                        end else begin
                            scrl_next  = 1'b0;
                            pos_next   = put_pos[AW-1:0];
                            state_next = S_BLANK;
                        end
                    end
                end
            end

            S_READ: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    out_data_sel = rd_ok_reg ? ram_rdata : '0;
                    state_next   = S_IDLE;
                end
            end

            S_COPY: begin
                // read cell idx+COLUMNS, write it back to idx in the following cycle
                if (cp_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < CW'(COPY_N)) begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(idx_reg + CW'(COLUMNS));
                    cp_dst_next  = idx_reg[AW-1:0];
                    cp_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end else begin
                    cp_pend_next = 1'b0;
                    idx_next     = CW'(CELLS - COLUMNS + 1);
                    state_next   = S_WIPE;
                end
            end

            S_WIPE: begin
                // zero the new bottom row past its first cell
                ram_we = 1'b1;
                if (idx_reg == CW'(CELLS - 1)) begin
                    state_next = S_BLANK;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_BLANK: begin
                if (out_free) begin
                    ram_we       = 1'b1;
                    ram_waddr    = pos_reg;
                    ram_wdata    = blank_cell;
                    cursor_next  = pos_reg;
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    out_cur_sel  = pos_reg;
                    out_scrl_sel = scrl_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_scrl_reg, out_data_reg, out_cur_reg};

`ifndef SYNTH
    // Cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cursor_reg) < 32'(CELLS))
        else $error("cursor beyond screen");

    // Column stays within a row.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < 32'(COLUMNS))
        else $error("column beyond row");

    // Copy never reads and writes the same cell in one cycle.
    a_copy_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide");

    // A pending result shows the cursor held in the block.
    a_out_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_cur_reg == cur_ext[CURSOR_W-1:0]))
        else $error("result cursor out of step");

    // A scroll always leaves the cursor at the start of the last row.
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_scrl_reg) |-> (cursor_reg == AW'(CELLS - COLUMNS)))
        else $error("cursor wrong after scroll");

    // Blank target of a put is always on screen.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BLANK) |-> (32'(pos_ext[AW-1:0]) < 32'(CELLS)))
        else $error("blank position off screen");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the text console character writer: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    // Screen geometry under test; the shadow screen below uses the same values.
    localparam int COLS      = 80;
    localparam int ROWS_N    = 24;
    localparam int CELLS     = COLS * ROWS_N;
    localparam int PHASE_LEN = 200;   // random beats per idling phase
    localparam int HOLD_LEN  = 400;   // long receiver hold-off, in cycles
    localparam int SETTLE    = 8;     // quiet cycles after the results have drained
    localparam int TAIL      = 100;   // quiet cycles at the end
    localparam int MAX_PRINT = 40;    // mismatch lines printed before going quiet

    // One result beat, split into its fields.
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [CELL_W-1:0]   cell_data;
        logic                scrolled;
    } console_result_t;

    // A row of the directed table: either an input beat (repeated reps times) or an
    // attribute write, which waits for the block to go idle first.
    typedef enum logic {
        ROW_BEAT,
        ROW_ATTR
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                op;
        logic [CHAR_W-1:0]   ch;      // char_code, or the attribute for ROW_ATTR
        logic [INDEX_W-1:0]  idx;
        int                  reps;
        bit                  typed;   // expected result given in the row itself
        logic [CURSOR_W-1:0] e_cur;
        logic [CELL_W-1:0]   e_cell;
        logic                e_scr;
    } stim_row_t;

    localparam int DIR_ROWS = 20;

    // DUT ports
    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] char_code, [18:8] read_index, [23:19] zero
    logic [0:0]  s_tuser;    // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [10:0] cursor_pos, [26:11] cell_data, [27] scrolled

    // Shadow copy of the screen, the cursor and the attribute register
    logic [CELL_W-1:0]   shadow_cells [CELLS];
    logic [CURSOR_W-1:0] shadow_cursor;
    logic [ATTR_W-1:0]   shadow_attr;

    // Results still owed by the block, oldest first
    console_result_t pending_results [$];

    stim_row_t dir_tab [DIR_ROWS];

    // Idling knobs, set by the stimulus process and read by both sides
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_ticket;         // bumped by the stimulus side to ask for a long hold-off
    int hold_seen;
    int hold_left;

    // Counters
    int err_count;
    int beats_sent;
    int reads_sent;
    int results_seen;
    int scrolls_seen;

    text_console_char_writer_top #(
        .COLUMNS (COLS),
        .ROWS    (ROWS_N)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, several times the slowest correct run even if every put scrolled.
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // One line per mismatch, quiet after the first few dozen.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINT)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Works out the result of one accepted beat and updates the shadow state.
    // Scroll: rows 1..ROWS-1 move up, cursor steps back a row, tail of the screen cleared.
    task automatic console_predict(input logic op, input logic [CHAR_W-1:0] ch,
                                   input logic [INDEX_W-1:0] idx,
                                   output console_result_t res);
        int                pos;
        int                i;
        logic [CELL_W-1:0] data;
        logic              scr;
        data = '0;
        scr  = 1'b0;
        if (op == OP_READ) begin
            if (int'(idx) < CELLS)
                data = shadow_cells[idx];
        end else begin
            pos = int'(shadow_cursor);
            if (ch == NEWLINE_CODE) begin
                pos = pos + COLS - (pos % COLS);
            end else begin
                shadow_cells[pos] = {shadow_attr, ch};
                pos++;
            end
            if (pos / COLS >= ROWS_N) begin
                for (i = 0; i < (ROWS_N - 1) * COLS; i++)
                    shadow_cells[i] = shadow_cells[i + COLS];
                pos = pos - COLS;
                for (i = pos; i < CELLS; i++)
                    shadow_cells[i] = '0;
                scr = 1'b1;
            end
            shadow_cells[pos] = {shadow_attr, BLANK_CODE};
            shadow_cursor     = pos[CURSOR_W-1:0];
        end
        res.cursor_pos = shadow_cursor;
        res.cell_data  = data;
        res.scrolled   = scr;
    endtask

    // Offers one beat from a falling edge and returns at the falling edge after it was
    // taken. Valid is left high so that a following beat goes out back to back.
    task automatic send_beat(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx,
                             input bit typed, input console_result_t typed_res);
        console_result_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, idx, ch};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // Beat taken at this edge: predict with the attribute in force now.
        console_predict(op, ch, idx, res);
        pending_results.push_back(typed ? typed_res : res);
        beats_sent++;
        if (op == OP_READ)
            reads_sent++;
        @(negedge aclk);
    endtask

    // Sender goes quiet until the block has handed back everything, plus a margin.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we      <= 1'b0;
        shadow_attr  = value;
        @(negedge aclk);
    endtask

    // Random beat: mostly puts with random characters and now and then a newline,
    // a quarter reads, a few of them past the end of the screen. The field the
    // operation ignores carries noise.
    task automatic send_random_beat();
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        console_result_t    unused;
        unused = '0;
        ch     = CHAR_W'($urandom_range(255));
        idx    = INDEX_W'($urandom_range(2047));
        if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) != 0)
                idx = INDEX_W'($urandom_range(CELLS - 1));
            send_beat(OP_READ, ch, idx, 1'b0, unused);
        end else begin
            if ($urandom_range(11) == 0)
                ch = NEWLINE_CODE;
            send_beat(OP_PUT, ch, idx, 1'b0, unused);
        end
    endtask

    // Receiver side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_tready  <= 1'b0;
        hold_seen  = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: every result beat against the oldest expectation, field by field.
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cursor_pos = m_tdata[10:0];
            got.cell_data  = m_tdata[26:11];
            got.scrolled   = m_tdata[27];
            results_seen++;
            if (got.scrolled)
                scrolls_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", int'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.cursor_pos !== want.cursor_pos)
                    report_mismatch("cursor_pos", int'(got.cursor_pos), int'(want.cursor_pos));
                if (got.cell_data !== want.cell_data)
                    report_mismatch("cell_data", int'(got.cell_data), int'(want.cell_data));
                if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
            end
        end
    end

    // Stimulus
    initial begin
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_PUT;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_ticket  = 0;
        err_count    = 0;
        beats_sent   = 0;
        reads_sent   = 0;
        results_seen = 0;
        scrolls_seen = 0;

        // Shadow state after reset: blank store, cursor home, attribute 7
        foreach (shadow_cells[i])
            shadow_cells[i] = '0;
        shadow_cursor = '0;
        shadow_attr   = ATTR_RESET;

        // Directed table; typed expectations follow the attribute writes in the table, from attribute 7 after reset.
        dir_tab = '{
            // reads of the blank store, including one past the end of the screen
            '{ROW_BEAT, OP_READ, 8'h00, 11'd0,    1,  1'b1, 11'd0,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'hff, 11'd1919, 1,  1'b1, 11'd0,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd2047, 1,  1'b1, 11'd0,    16'h0000, 1'b0},
            // puts: a letter, then the character extremes
            '{ROW_BEAT, OP_PUT,  8'h41, 11'd0,    1,  1'b1, 11'd1,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_PUT,  8'h00, 11'd2047, 1,  1'b1, 11'd2,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_PUT,  8'hff, 11'd0,    1,  1'b1, 11'd3,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd0,    1,  1'b1, 11'd3,    16'h0741, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd2,    1,  1'b1, 11'd3,    16'h07ff, 1'b0},
            // blank left at the cursor
            '{ROW_BEAT, OP_READ, 8'h00, 11'd3,    1,  1'b1, 11'd3,    16'h0720, 1'b0},
            '{ROW_BEAT, OP_PUT,  NEWLINE_CODE, 11'd0, 1, 1'b1, 11'd80, 16'h0000, 1'b0},
            // full attribute
            '{ROW_ATTR, OP_PUT,  8'hff, 11'd0,    0,  1'b0, 11'd0,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_PUT,  8'h7f, 11'd0,    1,  1'b1, 11'd81,   16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd80,   1,  1'b1, 11'd81,   16'hff7f, 1'b0},
            // zero attribute, then newlines down to the last row
            '{ROW_ATTR, OP_PUT,  8'h00, 11'd0,    0,  1'b0, 11'd0,    16'h0000, 1'b0},
            '{ROW_BEAT, OP_PUT,  NEWLINE_CODE, 11'd0, 22, 1'b0, 11'd0, 16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd1840, 1,  1'b1, 11'd1840, 16'h0020, 1'b0},
            // newline on the last row scrolls and leaves the cursor there
            '{ROW_BEAT, OP_PUT,  NEWLINE_CODE, 11'd0, 1, 1'b1, 11'd1840, 16'h0000, 1'b1},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd1760, 1,  1'b1, 11'd1840, 16'h0020, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd1919, 1,  1'b1, 11'd1840, 16'h0000, 1'b0},
            '{ROW_BEAT, OP_READ, 8'h00, 11'd0,    1,  1'b0, 11'd0,    16'h0000, 1'b0}
        };

        // Reset asserted from the start, released on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, no idling; s_tready stays low through the clearing pass
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_ATTR) begin
                wait_results_drained();
                write_attr(dir_tab[r].ch);
            end else begin
                repeat (dir_tab[r].reps)
                    send_beat(dir_tab[r].op, dir_tab[r].ch, dir_tab[r].idx, dir_tab[r].typed,
                              '{dir_tab[r].e_cur, dir_tab[r].e_cell, dir_tab[r].e_scr});
            end
        end

        // Random phase one: sender idles a little, receiver a lot
        wait_results_drained();
        write_attr(8'h5a);
        tx_idle_pct = 21;
        rx_idle_pct = 73;
        repeat (PHASE_LEN)
            send_random_beat();

        // Phase two: the other way round, with one pause until the block has drained
        wait_results_drained();
        write_attr(8'h00);
        tx_idle_pct = 73;
        rx_idle_pct = 21;
        repeat (PHASE_LEN / 2)
            send_random_beat();
        wait_results_drained();
        repeat (PHASE_LEN / 2)
            send_random_beat();

        // Phase three: no idling, opened by a long receiver hold-off while beats keep coming
        wait_results_drained();
        write_attr(8'hff);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_ticket++;
        repeat (PHASE_LEN / 2)
            send_random_beat();
        wait_results_drained();
        write_attr(ATTR_W'($urandom_range(255)));
        repeat (PHASE_LEN / 2)
            send_random_beat();

        // Drain and let the block settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (TAIL) @(negedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        $display("covered %0d beats (%0d reads, %0d puts) and %0d results, %0d of them scrolls,",
                 beats_sent, reads_sent, beats_sent - reads_sent, results_seen, scrolls_seen);
        $display("over five attribute settings, three stall mixes and one long output hold-off");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
